@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define CSWK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");

// clocked assertion that also holds during reset
`define CSWK_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

@@ rtl/cswk_pkg.sv @@
// shared types and constants of the crab steer wheel kinematics block
// no dependencies
package cswk_pkg;

	localparam int unsigned AtanLen   = 24;
	localparam int unsigned InShift   = 12;
	localparam logic [31:0] GainQ32   = 32'd2608131496;
	localparam int unsigned DivBits   = 28;

	localparam logic [1:0] RegWheelRadius = 2'd0;
	localparam logic [1:0] RegSpeedThr    = 2'd1;
	localparam logic [1:0] RegForceLimit  = 2'd2;

	localparam logic [15:0] RadiusReset = 16'd410;
	localparam logic [15:0] ThrReset    = 16'd3;
	localparam logic [15:0] ForceReset  = 16'd1280;

	// vector after pre-rotation into the right half plane
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        z;
	} cswk_item_t;

	typedef logic [31:0] atan_tab_t [AtanLen];

	localparam atan_tab_t AtanTab = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

@@ rtl/crab_steer_wheel_kinematics.sv @@
// channel | direction | signals
// in      | input     | in_valid, in_ready, vel_x, vel_y
// out     | output    | out_valid, out_ready, steer_angle, wheel_rate, spin_saturated, force_limit
// cfg     | apb       | psel, penable, pwrite, paddr, pwdata, prdata, pready
// the back end works a beat through the cordic loop (iteration count capped at 24), multiply,
// rounding, 28-step divide and output load; the back end handles one beat at a time.
// the front stage and a two-entry queue keep taking beats while the back end works.
// reset clears the held heading and loads the register defaults; no clearing pass.
// a stalled output holds its beat; the back end waits for it before loading the next result.
// top level of the crab steer wheel kinematics block
// depends on cswk_pkg, cswk_front, cswk_queue, cswk_back
module crab_steer_wheel_kinematics
	import cswk_pkg::*;
#(
	parameter int unsigned CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] steer_angle,
	output logic [15:0]        wheel_rate,
	output logic               spin_saturated,
	output logic [15:0]        force_limit,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned Iters = (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;

	logic [15:0] radius_q, thr_q, force_q;
	logic [1:0]  idx;
	logic        f_valid, f_ready, b_valid, b_ready;
	cswk_item_t  f_item, b_item;
	logic [15:0] angle_u;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusReset;
			thr_q    <= ThrReset;
			force_q  <= ForceReset;
		end else if (psel && penable && pwrite) begin
			case (idx)
				RegWheelRadius: radius_q <= pwdata[15:0];
				RegSpeedThr:    thr_q    <= pwdata[15:0];
				RegForceLimit:  force_q  <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			RegWheelRadius: prdata = {16'h0, radius_q};
			RegSpeedThr:    prdata = {16'h0, thr_q};
			RegForceLimit:  prdata = {16'h0, force_q};
			default:        prdata = 32'h0;
		endcase
	end

	cswk_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vel_x(vel_x), .vel_y(vel_y),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	cswk_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	cswk_back #(.Iters(Iters)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(b_valid), .item_ready(b_ready), .item(b_item),
		.wheel_radius(radius_q), .speed_threshold(thr_q), .spin_force_limit(force_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.steer_angle(angle_u), .wheel_rate(wheel_rate),
		.spin_saturated(spin_saturated), .force_limit(force_limit)
	);

	assign steer_angle = signed'(angle_u);

endmodule

@@ rtl/cswk_front.sv @@
// front end: takes velocity beats, scales them and turns them into the right half plane
// depends on cswk_pkg
module cswk_front
	import cswk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [15:0] vel_x,
	input  logic signed [15:0] vel_y,
	output logic              item_valid,
	input  logic              item_ready,
	output cswk_item_t        item
);

	logic       valid_s1;
	cswk_item_t item_s1;
	logic signed [31:0] sx, sy;
	cswk_item_t pre;

	assign sx = 32'(vel_x) <<< InShift;
	assign sy = 32'(vel_y) <<< InShift;

	always_comb begin
		pre.x = sx;
		pre.y = sy;
		pre.z = 32'h0;
		if (sx < 0) begin
			if (sy >= 0) begin
				pre.x = sy;
				pre.y = -sx;
				pre.z = 32'h40000000;
			end else begin
				pre.x = -sy;
				pre.y = sx;
				pre.z = 32'hC0000000;
			end
		end
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= pre;
		end
	end

endmodule

@@ rtl/cswk_queue.sv @@
// two-entry queue between the front end and the cordic back end
// depends on cswk_pkg
module cswk_queue
	import cswk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  cswk_item_t wr_item,
	output logic       rd_valid,
	input  logic       rd_ready,
	output cswk_item_t rd_item
);

	cswk_item_t mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_item  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

endmodule

@@ rtl/cswk_back.sv @@
// back end: iterative cordic vectoring, gain multiply, heading hold and serial divide
// depends on cswk_pkg
module cswk_back
	import cswk_pkg::*;
#(
	parameter int unsigned Iters = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  cswk_item_t  item,
	input  logic [15:0] wheel_radius,
	input  logic [15:0] speed_threshold,
	input  logic [15:0] spin_force_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] steer_angle,
	output logic [15:0] wheel_rate,
	output logic        spin_saturated,
	output logic [15:0] force_limit
);

	typedef enum logic [2:0] {
		IDLE, ROT, MUL, MAG, DIV, DONE
	} state_t;

	localparam int unsigned ItW = $clog2(AtanLen);
	localparam logic [ItW-1:0] LastIt = ItW'(Iters - 1);
	localparam logic [4:0] LastDiv = 5'(DivBits - 1);

	state_t             state_q;
	logic signed [31:0] x_q, y_q;
	logic [31:0]        z_q;
	logic [ItW-1:0]     it_q;
	logic [63:0]        prod_q;
	logic [15:0]        held_q;
	logic [27:0]        dvd_q;
	logic [27:0]        quo_q;
	logic [15:0]        rem_q;
	logic [4:0]         dcnt_q;

	logic signed [31:0] dx, dy;
	logic [31:0]        ux;
	logic [63:0]        rnd;
	logic [19:0]        mag_raw;
	logic [15:0]        mag;
	logic [15:0]        heading;
	logic [16:0]        rem_sh;
	logic               ge;
	logic [27:0]        quo_nx;

	assign dx      = y_q >>> it_q;
	assign dy      = x_q >>> it_q;
	assign ux      = (x_q > 0) ? x_q : 32'h0;
	assign rnd     = prod_q + (64'd1 << 43);
	assign mag_raw = rnd[63:44];
	assign mag     = (mag_raw > 20'd65535) ? 16'hFFFF : mag_raw[15:0];
	assign heading = 16'((z_q + 32'h8000) >> 16);
	assign rem_sh  = {rem_q, dvd_q[27]};
	assign ge      = rem_sh >= {1'b0, wheel_radius};
	assign quo_nx  = {quo_q[26:0], ge};

	assign item_ready = (state_q == IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			held_q         <= 16'h0;
			out_valid      <= 1'b0;
			it_q           <= '0;
			dcnt_q         <= 5'd0;
			x_q            <= '0;
			y_q            <= '0;
			z_q            <= '0;
			prod_q         <= '0;
			dvd_q          <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			steer_angle    <= 16'h0;
			wheel_rate     <= 16'h0;
			spin_saturated <= 1'b0;
			force_limit    <= 16'h0;
		end else begin
			// a beat taken while the next one is loaded keeps valid high
			if (out_valid && out_ready && state_q != DONE) out_valid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (item_valid) begin
						x_q     <= item.x;
						y_q     <= item.y;
						z_q     <= item.z;
						it_q    <= '0;
						state_q <= ROT;
					end
				end
				ROT: begin
					if (y_q >= 0) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + AtanTab[it_q];
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - AtanTab[it_q];
					end
					it_q <= it_q + 1'b1;
					if (it_q == LastIt) state_q <= MUL;
				end
				MUL: begin
					prod_q  <= 64'(ux) * 64'(GainQ32);
					state_q <= MAG;
				end
				MAG: begin
					if (mag > speed_threshold) held_q <= heading;
					dvd_q   <= {mag, 12'h0};
					quo_q   <= '0;
					rem_q   <= '0;
					dcnt_q  <= 5'd0;
					state_q <= DIV;
				end
				DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q  <= ge ? 16'(rem_sh - {1'b0, wheel_radius}) : rem_sh[15:0];
					quo_q  <= quo_nx;
					dvd_q  <= {dvd_q[26:0], 1'b0};
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == LastDiv) state_q <= DONE;
				end
				DONE: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						steer_angle <= 16'(16'h0 - held_q);
						if (wheel_radius == 16'h0 || quo_q[27:16] != 12'h0) begin
							wheel_rate     <= 16'hFFFF;
							spin_saturated <= 1'b1;
						end else begin
							wheel_rate     <= quo_q[15:0];
							spin_saturated <= 1'b0;
						end
						force_limit <= spin_force_limit;
						state_q     <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

@@ rtl/cswk_checker.sv @@
// port-level checker for the crab steer wheel kinematics block, with its bind
// depends on assert_macros.svh
`include "assert_macros.svh"
module cswk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] wheel_rate,
	input logic        spin_saturated,
	input logic [15:0] steer_angle,
	input logic        pready
);

	`CSWK_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(wheel_rate))
	`CSWK_ASSERT(a_angle_hold, clk, arst_n, out_valid && !out_ready |=> $stable(steer_angle))
	`CSWK_ASSERT(a_sat_max, clk, arst_n, out_valid && spin_saturated |-> wheel_rate == 16'hFFFF)
	`CSWK_ASSERT(a_no_beat_after_reset, clk, arst_n, $rose(arst_n) |-> !out_valid)
	`CSWK_ASSERT_ALWAYS(a_pready, clk, pready)

endmodule

bind crab_steer_wheel_kinematics cswk_checker u_cswk_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.wheel_rate(wheel_rate), .spin_saturated(spin_saturated),
	.steer_angle(steer_angle), .pready(pready)
);
